// ----- src/dtt_pkg.sv -----
// Shared types, constants and helper functions of the dirty tile tracker.
// Used by the controller, datapath, top level, checker and bench; it depends on nothing else.
`timescale 1ns / 1ps

package dtt_pkg;

   localparam int TILE_PIXELS_DEF = 16;
   localparam int MAX_TILES_DEF   = 4096;

   localparam int MODE_W     = 2;
   localparam int POS_W      = 10;
   localparam int SPAN_W     = 11;
   localparam int TILE_IDX_W = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CNT_W      = 12;

   localparam int FRAME_PIX_MAX  = 1024;
   localparam int FRAME_W_RESET  = 1024;
   localparam int FRAME_H_RESET  = 768;

   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 20;

   typedef enum logic [MODE_W-1:0] {
      MODE_MARK,
      MODE_QUERY,
      MODE_CLEAR,
      MODE_CLEAR_ALL
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_SETTLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FILL,
      ST_IDLE,
      ST_DECODE,
      ST_CLIP,
      ST_MARK,
      ST_WIPE,
      ST_TILE_DONE
   } state_type;

   typedef struct packed {
      logic load_item;
      logic load_quot;
      logic load_clip;
      logic div_start;
      logic latch_cols;
      logic latch_rows;
      logic sweep_init;
      logic sweep_write;
      logic sweep_ones;
      logic mark_step;
      logic tile_read;
      logic tile_finish;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic     size_wr;
      logic     div_done;
      logic     sweep_last;
      mode_type mode;
      logic     tile_bad;
      logic     reads_left;
      logic     write_pending;
   } status_type;

   // Quotient by the tile size through a scaled reciprocal; exact for operands
   // below 4096 and tile sizes from 2 to 64.
   function automatic logic [CNT_W-1:0] recip_div(input logic [CNT_W-1:0] value,
                                                  input logic [RECIP_W-1:0] recip);
      logic [CNT_W+RECIP_W-1:0] prod;
      prod = {{RECIP_W{1'b0}}, value} * {{CNT_W{1'b0}}, recip};
      return prod[RECIP_SHIFT+CNT_W-1:RECIP_SHIFT];
   endfunction

   function automatic logic [SPAN_W-1:0] clamp_pixels(input logic [SPAN_W-1:0] value);
      logic [SPAN_W-1:0] limit;
      limit = SPAN_W'(FRAME_PIX_MAX);
      return (value > limit) ? limit : value;
   endfunction

endpackage

// ----- src/dtt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the dirty bitmap, one tile row per word.
`timescale 1ns / 1ps

module dtt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/dtt_div.sv -----
// Restoring divider of a constant dividend by a variable divisor, one bit a cycle.
// Stand-alone; gives the row limit that keeps the tile count within the bitmap.
`timescale 1ns / 1ps

module dtt_div #(
   parameter int DIVIDEND = 4096,
   parameter int DVD_W    = 13,
   parameter int DIV_W    = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dsr_ff;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = trial >= {1'b0, dsr_ff};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = DVD_W'(DIVIDEND);
         rem_in = '0;
         cnt_in = STEP_W'(DVD_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], fits};
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ----- src/dtt_ctrl.sv -----
// Controller state machine of the dirty tile tracker.
// Depends on dtt_pkg; drives the datapath through cmd_type, reads status_type.
`timescale 1ns / 1ps

module dtt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  dtt_pkg::status_type status,
   output dtt_pkg::cmd_type    cmd
);

   dtt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtt_pkg::ST_SETTLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         dtt_pkg::ST_SETTLE: begin
            state_in = dtt_pkg::ST_DIV_START;
         end
         dtt_pkg::ST_DIV_START: begin
            cmd.latch_cols = 1'b1;
            cmd.div_start  = 1'b1;
            state_in       = dtt_pkg::ST_DIV_WAIT;
         end
         dtt_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.latch_rows = 1'b1;
               cmd.sweep_init = 1'b1;
               state_in       = dtt_pkg::ST_FILL;
            end
         end
         dtt_pkg::ST_FILL: begin
            cmd.sweep_write = 1'b1;
            cmd.sweep_ones  = 1'b1;
            if (status.sweep_last) begin
               state_in = dtt_pkg::ST_IDLE;
            end
         end
         dtt_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load_item = 1'b1;
               state_in      = dtt_pkg::ST_DECODE;
            end
         end
         dtt_pkg::ST_DECODE: begin
            unique case (status.mode) inside
               dtt_pkg::MODE_MARK: begin
                  cmd.load_quot = 1'b1;
                  state_in      = dtt_pkg::ST_CLIP;
               end
               dtt_pkg::MODE_QUERY, dtt_pkg::MODE_CLEAR: begin
                  if (status.tile_bad) begin
                     cmd.respond = 1'b1;
                     state_in    = dtt_pkg::ST_IDLE;
                  end else begin
                     cmd.tile_read = 1'b1;
                     state_in      = dtt_pkg::ST_TILE_DONE;
                  end
               end
               dtt_pkg::MODE_CLEAR_ALL: begin
                  cmd.sweep_init = 1'b1;
                  state_in       = dtt_pkg::ST_WIPE;
               end
               default: begin
                  state_in = dtt_pkg::ST_IDLE;
               end
            endcase
         end
         dtt_pkg::ST_CLIP: begin
            cmd.load_clip = 1'b1;
            state_in      = dtt_pkg::ST_MARK;
         end
         dtt_pkg::ST_MARK: begin
            cmd.mark_step = 1'b1;
            if (!status.reads_left && !status.write_pending) begin
               cmd.respond = 1'b1;
               state_in    = dtt_pkg::ST_IDLE;
            end
         end
         dtt_pkg::ST_WIPE: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) begin
               cmd.respond = 1'b1;
               state_in    = dtt_pkg::ST_IDLE;
            end
         end
         dtt_pkg::ST_TILE_DONE: begin
            cmd.tile_finish = 1'b1;
            cmd.respond     = 1'b1;
            state_in        = dtt_pkg::ST_IDLE;
         end
         default: begin
            state_in = dtt_pkg::ST_SETTLE;
         end
      endcase
      if (status.size_wr) begin
         state_in = dtt_pkg::ST_SETTLE;
      end
   end

   assign busy = (state_ff != dtt_pkg::ST_IDLE);

endmodule

// ----- src/dtt_datapath.sv -----
// Datapath of the dirty tile tracker: size registers, tile arithmetic, bitmap RAM.
// Depends on dtt_pkg, dtt_ram and dtt_div; steered by dtt_ctrl through cmd_type.
`timescale 1ns / 1ps

module dtt_datapath #(
   parameter int TILE_PIXELS = dtt_pkg::TILE_PIXELS_DEF,
   parameter int MAX_TILES   = dtt_pkg::MAX_TILES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [dtt_pkg::MODE_W-1:0]        req_mode,
   input  logic [dtt_pkg::POS_W-1:0]         req_x_pos,
   input  logic [dtt_pkg::POS_W-1:0]         req_y_pos,
   input  logic [dtt_pkg::SPAN_W-1:0]        req_rect_width,
   input  logic [dtt_pkg::SPAN_W-1:0]        req_rect_height,
   input  logic [dtt_pkg::TILE_IDX_W-1:0]    req_tile_col,
   input  logic [dtt_pkg::TILE_IDX_W-1:0]    req_tile_row,
   input  logic                              csr_valid,
   input  logic [dtt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dtt_pkg::SPAN_W-1:0]        csr_wdata,
   input  dtt_pkg::cmd_type                  cmd,
   output dtt_pkg::status_type               status,
   output logic                              rsp_valid,
   output logic                              rsp_tile_dirty,
   output logic                              rsp_bad_tile
);

   localparam int CW        = dtt_pkg::CNT_W;
   localparam int SW        = dtt_pkg::SPAN_W;
   localparam int MAX_SPAN  = (dtt_pkg::FRAME_PIX_MAX + TILE_PIXELS - 1) / TILE_PIXELS;
   localparam int TILE_SPAN = (MAX_SPAN < MAX_TILES) ? MAX_SPAN : MAX_TILES;
   localparam int RA_W      = $clog2(TILE_SPAN);
   localparam int LIM_W     = $clog2(MAX_TILES + 1);
   localparam int CMP_W     = (LIM_W > CW) ? LIM_W : CW;
   localparam int RECIP_I   = ((1 << dtt_pkg::RECIP_SHIFT) + TILE_PIXELS - 1) / TILE_PIXELS;
   localparam logic [dtt_pkg::RECIP_W-1:0] RECIP = dtt_pkg::RECIP_W'(RECIP_I);
   localparam logic [CW-1:0] ROUND_UP = CW'(TILE_PIXELS - 1);

   logic [SW-1:0]            frame_width_ff, frame_height_ff;
   logic                     size_wr;
   logic [CW-1:0]            cols_raw_ff, rows_raw_ff;
   logic [CW-1:0]            cols_sat, rows_eff;
   logic [CW-1:0]            tile_cols_ff, tile_rows_ff;

   dtt_pkg::mode_type                mode_ff;
   logic [dtt_pkg::POS_W-1:0]        x_ff, y_ff;
   logic [SW-1:0]                    w_ff, h_ff;
   logic [dtt_pkg::TILE_IDX_W-1:0]   col_ff, row_ff;

   logic [CW-1:0]            sx_ff, sy_ff, ex_ff, ey_ff;
   logic [CW-1:0]            ex_clip, ey_clip;
   logic [TILE_SPAN-1:0]     mask_in, mask_ff;
   logic [TILE_SPAN-1:0]     col_onehot;
   logic [CW-1:0]            eyc_ff, rd_row_ff;
   logic                     empty_ff;
   logic [RA_W-1:0]          wr_row_ff;
   logic                     wpend_ff;
   logic                     reads_left;
   logic [RA_W-1:0]          sweep_ff;
   logic                     tile_bad;
   logic [CW-1:0]            row_ext;

   logic                     div_done;
   logic [LIM_W-1:0]         div_quot;

   logic                     ram_wr_en, ram_rd_en;
   logic [RA_W-1:0]          ram_wr_addr, ram_rd_addr;
   logic [TILE_SPAN-1:0]     ram_wr_data, ram_rd_data;

   logic                     rsp_valid_ff, rsp_tile_dirty_ff, rsp_bad_tile_ff;

   // Size registers and the tile counts that follow from them.
   assign size_wr = csr_valid && (csr_index == dtt_pkg::CSR_FRAME_WIDTH ||
                                  csr_index == dtt_pkg::CSR_FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= SW'(dtt_pkg::FRAME_W_RESET);
         frame_height_ff <= SW'(dtt_pkg::FRAME_H_RESET);
      end else if (csr_valid) begin
         if (csr_index == dtt_pkg::CSR_FRAME_WIDTH) begin
            frame_width_ff <= csr_wdata;
         end
         if (csr_index == dtt_pkg::CSR_FRAME_HEIGHT) begin
            frame_height_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cols_raw_ff <= dtt_pkg::recip_div(CW'(dtt_pkg::clamp_pixels(frame_width_ff)) + ROUND_UP,
                                        RECIP);
      rows_raw_ff <= dtt_pkg::recip_div(CW'(dtt_pkg::clamp_pixels(frame_height_ff)) + ROUND_UP,
                                        RECIP);
   end

   assign cols_sat = (cols_raw_ff > CW'(TILE_SPAN)) ? CW'(TILE_SPAN) : cols_raw_ff;

   dtt_div #(
      .DIVIDEND (MAX_TILES),
      .DVD_W    (LIM_W),
      .DIV_W    (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (cols_sat),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rows_eff = (tile_cols_ff != '0 && CMP_W'(rows_raw_ff) > CMP_W'(div_quot)) ?
                     CW'(div_quot) : rows_raw_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_cols) begin
         tile_cols_ff <= cols_sat;
      end
      if (cmd.latch_rows) begin
         tile_rows_ff <= rows_eff;
      end
   end

   // Item capture and rectangle arithmetic.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff <= dtt_pkg::mode_type'(req_mode);
         x_ff    <= req_x_pos;
         y_ff    <= req_y_pos;
         w_ff    <= req_rect_width;
         h_ff    <= req_rect_height;
         col_ff  <= req_tile_col;
         row_ff  <= req_tile_row;
      end
      if (cmd.load_quot) begin
         sx_ff <= dtt_pkg::recip_div(CW'(x_ff), RECIP);
         sy_ff <= dtt_pkg::recip_div(CW'(y_ff), RECIP);
         ex_ff <= dtt_pkg::recip_div(CW'(x_ff) + CW'(w_ff) + ROUND_UP, RECIP);
         ey_ff <= dtt_pkg::recip_div(CW'(y_ff) + CW'(h_ff) + ROUND_UP, RECIP);
      end
   end

   always_comb begin
      ex_clip = (ex_ff > tile_cols_ff) ? tile_cols_ff : ex_ff;
      ey_clip = (ey_ff > tile_rows_ff) ? tile_rows_ff : ey_ff;
      for (int c = 0; c < TILE_SPAN; c++) begin
         mask_in[c]    = (CW'(c) >= sx_ff) && (CW'(c) < ex_clip);
         col_onehot[c] = (CW'(c) == CW'(col_ff));
      end
   end

   assign reads_left = !empty_ff && (rd_row_ff < eyc_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_clip) begin
         mask_ff   <= mask_in;
         eyc_ff    <= ey_clip;
         rd_row_ff <= sy_ff;
         empty_ff  <= (w_ff == '0) || (h_ff == '0) || (sx_ff >= ex_clip) ||
                      (sy_ff >= ey_clip);
      end else if (cmd.mark_step && reads_left) begin
         rd_row_ff <= rd_row_ff + CW'(1);
         wr_row_ff <= rd_row_ff[RA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpend_ff <= 1'b0;
      end else if (cmd.load_clip) begin
         wpend_ff <= 1'b0;
      end else if (cmd.mark_step) begin
         wpend_ff <= reads_left;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_init) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_write) begin
         sweep_ff <= sweep_ff + RA_W'(1);
      end
   end

   assign row_ext  = CW'(row_ff);
   assign tile_bad = (CW'(col_ff) >= tile_cols_ff) || (row_ext >= tile_rows_ff);

   // Bitmap RAM access.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = sweep_ff;
      ram_wr_data = {TILE_SPAN{cmd.sweep_ones}};
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_row_ff[RA_W-1:0];
      if (cmd.sweep_write) begin
         ram_wr_en = 1'b1;
      end else if (cmd.mark_step && wpend_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = wr_row_ff;
         ram_wr_data = ram_rd_data | mask_ff;
      end else if (cmd.tile_finish && mode_ff == dtt_pkg::MODE_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = row_ext[RA_W-1:0];
         ram_wr_data = ram_rd_data & ~col_onehot;
      end
      if (cmd.mark_step && reads_left) begin
         ram_rd_en = 1'b1;
      end else if (cmd.tile_read) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = row_ext[RA_W-1:0];
      end
   end

   dtt_ram #(
      .WIDTH (TILE_SPAN),
      .DEPTH (TILE_SPAN)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_bad_tile_ff   <= (mode_ff == dtt_pkg::MODE_QUERY ||
                               mode_ff == dtt_pkg::MODE_CLEAR) && tile_bad;
         rsp_tile_dirty_ff <= (mode_ff == dtt_pkg::MODE_QUERY) && !tile_bad &&
                              (|(ram_rd_data & col_onehot));
      end
   end

   always_comb begin
      status.size_wr       = size_wr;
      status.div_done      = div_done;
      status.sweep_last    = (sweep_ff == RA_W'(TILE_SPAN - 1));
      status.mode          = mode_ff;
      status.tile_bad      = tile_bad;
      status.reads_left    = reads_left;
      status.write_pending = wpend_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tile_dirty = rsp_tile_dirty_ff;
   assign rsp_bad_tile   = rsp_bad_tile_ff;

endmodule

// ----- src/dirty_tile_tracker.sv -----
// From the start transfer to the result strobe, a rectangle mark passes decode and clip and then
// does one row read-modify-write per cycle over the tile rows it touches; a query or tile clear
// reads its tile row, a tile outside the frame answers from decode, and clear all writes all R rows.
// R = ceil(1024 / TILE_PIXELS) rows, at most MAX_TILES. A new item is taken in the cycle its
// predecessor's result strobe shows; the receiver never stalls. After reset and each size
// register write the bitmap is refilled dirty while busy stays high.
`timescale 1ns / 1ps

module dirty_tile_tracker #(
   parameter int TILE_PIXELS = dtt_pkg::TILE_PIXELS_DEF,
   parameter int MAX_TILES   = dtt_pkg::MAX_TILES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dtt_pkg::MODE_W-1:0]        req_mode,
   input  logic [dtt_pkg::POS_W-1:0]         req_x_pos,
   input  logic [dtt_pkg::POS_W-1:0]         req_y_pos,
   input  logic [dtt_pkg::SPAN_W-1:0]        req_rect_width,
   input  logic [dtt_pkg::SPAN_W-1:0]        req_rect_height,
   input  logic [dtt_pkg::TILE_IDX_W-1:0]    req_tile_col,
   input  logic [dtt_pkg::TILE_IDX_W-1:0]    req_tile_row,
   output logic                              rsp_valid,
   output logic                              rsp_tile_dirty,
   output logic                              rsp_bad_tile,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dtt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dtt_pkg::SPAN_W-1:0]        csr_wdata
);

   dtt_pkg::cmd_type    cmd;
   dtt_pkg::status_type status;

   assign csr_ready = 1'b1;

   dtt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   dtt_datapath #(
      .TILE_PIXELS (TILE_PIXELS),
      .MAX_TILES   (MAX_TILES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_tile_col    (req_tile_col),
      .req_tile_row    (req_tile_row),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_tile_dirty  (rsp_tile_dirty),
      .rsp_bad_tile    (rsp_bad_tile)
   );

endmodule

// ----- src/dtt_checker.sv -----
// Port-level assertions of the dirty tile tracker and the bind that attaches them.
// Depends on dtt_pkg and on the ports of dirty_tile_tracker.
`timescale 1ns / 1ps

module dtt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic                           rsp_tile_dirty,
   input logic                           rsp_bad_tile,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [dtt_pkg::CSR_IDX_W-1:0]  csr_index
);

   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in two consecutive cycles");

   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tile_dirty) |-> !rsp_bad_tile)
      else $error("dirty tile reported outside the frame");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an input transfer");

   a_reset_busy: assert property (@(posedge clock)
      reset |=> busy)
      else $error("block not refilling the bitmap after reset");

   a_resize_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index == dtt_pkg::CSR_FRAME_WIDTH ||
                                  csr_index == dtt_pkg::CSR_FRAME_HEIGHT)) |=> busy)
      else $error("busy not raised after a size register transfer");

endmodule

bind dirty_tile_tracker dtt_checker u_checker (.*);

// ----- tb/dirty_tile_tracker_tb.sv -----
// Self-checking testbench for the dirty tile tracker: directed and random tile operations
// and frame size writes, predicted against a bitmap model kept in the bench.
// Depends on dtt_pkg and the dirty_tile_tracker top level only.
`timescale 1ns / 1ps

module dirty_tile_tracker_tb;

   localparam int unsigned TILE_PX     = dtt_pkg::TILE_PIXELS_DEF;
   localparam int unsigned TILE_LIMIT  = dtt_pkg::MAX_TILES_DEF;
   localparam int unsigned PIX_MAX     = dtt_pkg::FRAME_PIX_MAX;
   localparam int          POS_BITS    = dtt_pkg::POS_W;
   localparam int          SPAN_BITS   = dtt_pkg::SPAN_W;
   localparam int          TILE_BITS   = dtt_pkg::TILE_IDX_W;
   localparam int          PHASES      = 11;
   localparam int          PHASE_ITEMS = 55;
   localparam int          TAIL_CYCLES = 200;
   localparam int          CYCLE_LIMIT = 600000;

   localparam logic [dtt_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [dtt_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef enum logic [1:0] {
      JOB_ITEM,
      JOB_CSR,
      JOB_DRAIN
   } job_kind_type;

   typedef struct packed {
      job_kind_type                     kind;
      logic                             idle_ok;
      dtt_pkg::mode_type                mode;
      logic [dtt_pkg::POS_W-1:0]        x;
      logic [dtt_pkg::POS_W-1:0]        y;
      logic [dtt_pkg::SPAN_W-1:0]       w;
      logic [dtt_pkg::SPAN_W-1:0]       h;
      logic [dtt_pkg::TILE_IDX_W-1:0]   col;
      logic [dtt_pkg::TILE_IDX_W-1:0]   row;
      logic [dtt_pkg::CSR_IDX_W-1:0]    csr_idx;
      logic [dtt_pkg::SPAN_W-1:0]       csr_val;
   } op_job_type;

   typedef struct packed {
      logic dirty;
      logic bad;
   } tile_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [dtt_pkg::MODE_W-1:0]       req_mode = '0;
   logic [dtt_pkg::POS_W-1:0]        req_x_pos = '0;
   logic [dtt_pkg::POS_W-1:0]        req_y_pos = '0;
   logic [dtt_pkg::SPAN_W-1:0]       req_rect_width = '0;
   logic [dtt_pkg::SPAN_W-1:0]       req_rect_height = '0;
   logic [dtt_pkg::TILE_IDX_W-1:0]   req_tile_col = '0;
   logic [dtt_pkg::TILE_IDX_W-1:0]   req_tile_row = '0;
   logic                             rsp_valid;
   logic                             rsp_tile_dirty;
   logic                             rsp_bad_tile;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [dtt_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [dtt_pkg::SPAN_W-1:0]       csr_wdata = '0;

   op_job_type              op_queue[$];
   tile_result_type         tile_status_q[$];

   bit                      tile_map[TILE_LIMIT];
   int unsigned             frame_w_reg;
   int unsigned             frame_h_reg;
   int unsigned             map_cols;
   int unsigned             map_rows;

   int unsigned             gen_fw;
   int unsigned             gen_fh;
   bit                      gen_idle_ok;

   int                      req_taken = 0;
   int                      req_handled = 0;
   int                      csr_taken = 0;
   int                      csr_handled = 0;
   bit                      item_active = 1'b0;
   bit                      item_idles = 1'b0;
   bit                      csr_active = 1'b0;
   int                      gap_left = 0;
   int                      error_count = 0;
   int                      cycle_count = 0;

   dirty_tile_tracker uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_tile_col    (req_tile_col),
      .req_tile_row    (req_tile_row),
      .rsp_valid       (rsp_valid),
      .rsp_tile_dirty  (rsp_tile_dirty),
      .rsp_bad_tile    (rsp_bad_tile),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned tiles_for(input int unsigned pixels);
      int unsigned clamped;
      clamped = (pixels > PIX_MAX) ? PIX_MAX : pixels;
      return (clamped + TILE_PX - 1) / TILE_PX;
   endfunction

   function automatic void refit_map();
      map_cols = tiles_for(frame_w_reg);
      map_rows = tiles_for(frame_h_reg);
      if (map_cols > TILE_LIMIT) begin
         map_cols = TILE_LIMIT;
      end
      if (map_cols != 0 && map_rows > TILE_LIMIT / map_cols) begin
         map_rows = TILE_LIMIT / map_cols;
      end
      for (int i = 0; i < TILE_LIMIT; i++) begin
         tile_map[i] = 1'b1;
      end
   endfunction

   function automatic void write_frame_reg(input logic [dtt_pkg::CSR_IDX_W-1:0] idx,
                                           input logic [dtt_pkg::SPAN_W-1:0] value);
      if (idx == dtt_pkg::CSR_FRAME_WIDTH) begin
         frame_w_reg = 32'(value);
         refit_map();
      end else if (idx == dtt_pkg::CSR_FRAME_HEIGHT) begin
         frame_h_reg = 32'(value);
         refit_map();
      end
   endfunction

   function automatic tile_result_type apply_tile_op(input dtt_pkg::mode_type mode,
                                                     input int unsigned x,
                                                     input int unsigned y,
                                                     input int unsigned w,
                                                     input int unsigned h,
                                                     input int unsigned col,
                                                     input int unsigned row);
      tile_result_type outcome;
      int unsigned     sx, sy, ex, ey, r, c, idx;
      outcome = '0;
      case (mode)
         dtt_pkg::MODE_MARK: begin
            if (w != 0 && h != 0) begin
               sx = x / TILE_PX;
               sy = y / TILE_PX;
               ex = (x + w + TILE_PX - 1) / TILE_PX;
               ey = (y + h + TILE_PX - 1) / TILE_PX;
               if (ex > map_cols) ex = map_cols;
               if (ey > map_rows) ey = map_rows;
               for (r = sy; r < ey; r++) begin
                  for (c = sx; c < ex; c++) begin
                     idx = r * map_cols + c;
                     if (idx < TILE_LIMIT) tile_map[idx] = 1'b1;
                  end
               end
            end
         end
         dtt_pkg::MODE_QUERY, dtt_pkg::MODE_CLEAR: begin
            if (col >= map_cols || row >= map_rows) begin
               outcome.bad = 1'b1;
            end else begin
               idx = row * map_cols + col;
               if (idx < TILE_LIMIT) begin
                  if (mode == dtt_pkg::MODE_QUERY) begin
                     outcome.dirty = tile_map[idx];
                  end else begin
                     tile_map[idx] = 1'b0;
                  end
               end
            end
         end
         default: begin
            for (idx = 0; idx < TILE_LIMIT; idx++) begin
               tile_map[idx] = 1'b0;
            end
         end
      endcase
      return outcome;
   endfunction

   task automatic push_mark(input int unsigned x, input int unsigned y,
                            input int unsigned w, input int unsigned h);
      op_job_type job;
      job = '0;
      job.kind = JOB_ITEM;
      job.idle_ok = gen_idle_ok;
      job.mode = dtt_pkg::MODE_MARK;
      job.x = POS_BITS'(x);
      job.y = POS_BITS'(y);
      job.w = SPAN_BITS'(w);
      job.h = SPAN_BITS'(h);
      job.col = TILE_BITS'($urandom_range(0, 63));
      job.row = TILE_BITS'($urandom_range(0, 63));
      op_queue.push_back(job);
   endtask

   task automatic push_tile(input dtt_pkg::mode_type mode, input int unsigned col,
                            input int unsigned row);
      op_job_type job;
      job = '0;
      job.kind = JOB_ITEM;
      job.idle_ok = gen_idle_ok;
      job.mode = mode;
      job.x = POS_BITS'($urandom_range(0, 1023));
      job.y = POS_BITS'($urandom_range(0, 1023));
      job.w = SPAN_BITS'($urandom_range(0, 1024));
      job.h = SPAN_BITS'($urandom_range(0, 1024));
      job.col = TILE_BITS'(col);
      job.row = TILE_BITS'(row);
      op_queue.push_back(job);
   endtask

   task automatic push_csr(input logic [dtt_pkg::CSR_IDX_W-1:0] idx,
                           input logic [dtt_pkg::SPAN_W-1:0] value);
      op_job_type job;
      job = '0;
      job.kind = JOB_CSR;
      job.csr_idx = idx;
      job.csr_val = value;
      op_queue.push_back(job);
      if (idx == dtt_pkg::CSR_FRAME_WIDTH) gen_fw = 32'(value);
      if (idx == dtt_pkg::CSR_FRAME_HEIGHT) gen_fh = 32'(value);
   endtask

   task automatic push_drain();
      op_job_type job;
      job = '0;
      job.kind = JOB_DRAIN;
      op_queue.push_back(job);
   endtask

   function automatic int unsigned rand_span();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return 0;
      if (pick < 3) return $urandom_range(0, 1024);
      return $urandom_range(1, 48);
   endfunction

   function automatic int unsigned rand_pixel(input int unsigned limit);
      int unsigned clamped;
      clamped = (limit > PIX_MAX) ? PIX_MAX : limit;
      if (clamped != 0 && $urandom_range(0, 7) != 0) return $urandom_range(0, clamped - 1);
      return $urandom_range(0, 1023);
   endfunction

   function automatic int unsigned rand_tile_coord(input int unsigned count);
      if (count != 0 && $urandom_range(0, 5) != 0) return $urandom_range(0, count - 1);
      return $urandom_range(0, 63);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            tile_status_q.push_back(apply_tile_op(dtt_pkg::mode_type'(req_mode),
                                                  32'(req_x_pos), 32'(req_y_pos),
                                                  32'(req_rect_width), 32'(req_rect_height),
                                                  32'(req_tile_col), 32'(req_tile_row)));
            req_taken++;
         end
         if (csr_valid && csr_ready) begin
            write_frame_reg(csr_index, csr_wdata);
            csr_taken++;
         end
      end
   end

   always @(negedge clock) begin
      op_job_type job;
      if (!reset) begin
         if (item_active && req_handled != req_taken) begin
            item_active = 1'b0;
            req_handled = req_taken;
            if (item_idles && $urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 9);
         end
         if (csr_active && csr_handled != csr_taken) begin
            csr_active = 1'b0;
            csr_handled = csr_taken;
         end
         if (!item_active && !csr_active && op_queue.size() != 0) begin
            if (gap_left != 0) begin
               gap_left--;
            end else begin
               job = op_queue[0];
               case (job.kind)
                  JOB_ITEM: begin
                     void'(op_queue.pop_front());
                     item_active = 1'b1;
                     item_idles = job.idle_ok;
                     req_mode <= job.mode;
                     req_x_pos <= job.x;
                     req_y_pos <= job.y;
                     req_rect_width <= job.w;
                     req_rect_height <= job.h;
                     req_tile_col <= job.col;
                     req_tile_row <= job.row;
                  end
                  JOB_CSR: begin
                     if (tile_status_q.size() == 0 && !busy) begin
                        void'(op_queue.pop_front());
                        csr_active = 1'b1;
                        csr_index <= job.csr_idx;
                        csr_wdata <= job.csr_val;
                     end
                  end
                  default: begin
                     if (tile_status_q.size() == 0) void'(op_queue.pop_front());
                  end
               endcase
            end
         end
         start <= item_active;
         csr_valid <= csr_active;
      end
   end

   always @(posedge clock) begin
      tile_result_type want;
      if (!reset && rsp_valid) begin
         if (tile_status_q.size() == 0) begin
            $error("unexpected result transfer: tile_dirty %0d, bad_tile %0d",
                   rsp_tile_dirty, rsp_bad_tile);
            error_count++;
         end else begin
            want = tile_status_q.pop_front();
            if (rsp_tile_dirty !== want.dirty) begin
               $error("tile_dirty: expected %0d, actual %0d", want.dirty, rsp_tile_dirty);
               error_count++;
            end
            if (rsp_bad_tile !== want.bad) begin
               $error("bad_tile: expected %0d, actual %0d", want.bad, rsp_bad_tile);
               error_count++;
            end
         end
      end
   end

   initial begin
      int unsigned pick, fw, fh, cols, rows;
      frame_w_reg = dtt_pkg::FRAME_W_RESET;
      frame_h_reg = dtt_pkg::FRAME_H_RESET;
      refit_map();
      gen_fw = dtt_pkg::FRAME_W_RESET;
      gen_fh = dtt_pkg::FRAME_H_RESET;
      gen_idle_ok = 1'b1;

      // The default frame is 64 tile columns by 48 tile rows, all dirty.
      push_tile(dtt_pkg::MODE_QUERY, 0, 0);
      push_tile(dtt_pkg::MODE_QUERY, 63, 47);
      push_tile(dtt_pkg::MODE_QUERY, 63, 48);
      push_tile(dtt_pkg::MODE_QUERY, 0, 63);
      push_tile(dtt_pkg::MODE_CLEAR_ALL, $urandom_range(0, 63), $urandom_range(0, 63));
      push_tile(dtt_pkg::MODE_QUERY, 5, 5);
      push_mark(0, 0, 0, 100);
      push_mark(0, 0, 100, 0);
      push_mark(1023, 1023, 1024, 1024);
      push_mark(1023, 0, 1, 1);
      push_tile(dtt_pkg::MODE_QUERY, 63, 0);
      push_tile(dtt_pkg::MODE_QUERY, 63, 1);
      push_mark(0, 760, 1024, 1024);
      push_tile(dtt_pkg::MODE_QUERY, 20, 47);
      push_tile(dtt_pkg::MODE_QUERY, 20, 46);
      push_tile(dtt_pkg::MODE_CLEAR, 63, 0);
      push_tile(dtt_pkg::MODE_QUERY, 63, 0);
      push_tile(dtt_pkg::MODE_CLEAR, 63, 63);
      push_mark(17, 33, 40, 20);
      push_tile(dtt_pkg::MODE_QUERY, 3, 3);
      push_tile(dtt_pkg::MODE_QUERY, 4, 3);
      push_tile(dtt_pkg::MODE_QUERY, 1, 2);
      push_mark(0, 0, 1024, 1024);
      push_tile(dtt_pkg::MODE_QUERY, 5, 5);
      push_drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin fw = 1; fh = 1; end
            1: begin fw = 1024; fh = 1024; end
            2: begin fw = 2047; fh = 0; end
            3: begin fw = 0; fh = 1024; end
            4: begin fw = 17; fh = 33; end
            5: begin fw = 1024; fh = 768; end
            PHASES - 1: begin fw = 1024; fh = 1024; end
            default: begin
               fw = $urandom_range(1, 1024);
               fh = $urandom_range(1, 1024);
               if ($urandom_range(0, 3) == 0) fw = $urandom_range(1025, 2047);
            end
         endcase
         push_csr(dtt_pkg::CSR_FRAME_WIDTH, SPAN_BITS'(fw));
         push_csr(dtt_pkg::CSR_FRAME_HEIGHT, SPAN_BITS'(fh));
         if (phase == 3) begin
            push_csr(CSR_SPARE_LO, SPAN_BITS'($urandom_range(0, 2047)));
            push_csr(CSR_SPARE_HI, SPAN_BITS'($urandom_range(0, 2047)));
         end
         cols = tiles_for(gen_fw);
         rows = tiles_for(gen_fh);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            gen_idle_ok = (phase != PHASES - 1) && ((n / 20) % 3 != 2);
            if (phase == PHASES / 2 && n == PHASE_ITEMS / 2) push_drain();
            pick = $urandom_range(0, 19);
            if (pick < 6) begin
               push_mark(rand_pixel(gen_fw), rand_pixel(gen_fh), rand_span(), rand_span());
            end else if (pick < 13) begin
               push_tile(dtt_pkg::MODE_QUERY, rand_tile_coord(cols), rand_tile_coord(rows));
            end else if (pick < 17) begin
               push_tile(dtt_pkg::MODE_CLEAR, rand_tile_coord(cols), rand_tile_coord(rows));
            end else if (pick == 17) begin
               push_tile(dtt_pkg::MODE_CLEAR_ALL, $urandom_range(0, 63), $urandom_range(0, 63));
            end else if ($urandom_range(0, 3) == 0) begin
               push_mark($urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1024), $urandom_range(0, 1024));
            end else begin
               push_tile(dtt_pkg::mode_type'($urandom_range(1, 3)), $urandom_range(0, 63),
                         $urandom_range(0, 63));
            end
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (op_queue.size() != 0 || item_active || csr_active) @(posedge clock);
      while (tile_status_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
